### src/first_fit_range_allocator_partial_free_unit_macros.svh
// assertion helpers for the first-fit range allocator
`ifndef FIRST_FIT_RANGE_ALLOCATOR_PARTIAL_FREE_UNIT_MACROS_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_PARTIAL_FREE_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define FFRA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffra check failed");

// next-cycle implication, disabled in reset
`define FFRA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffra check failed");

`endif

### src/ffra_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffra_pkg
// shared types, codes and widths of the first-fit range allocator
// ---------------------------------------------------------------------------
package ffra_pkg;

   localparam int ADDR_W = 36;
   localparam int SIZE_W = 37;
   localparam int LEN_W  = 32;
   localparam int ST_W   = 3;

   // response status codes
   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_NOFIT    = 3'd1;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [ST_W-1:0] ST_BADLEN   = 3'd4;

   // request kinds
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // configuration register indexes
   localparam logic REG_BASE = 1'b0;
   localparam logic REG_SIZE = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [SIZE_W-1:0] size;
      logic              free;
   } blk_type;

   typedef enum logic [4:0] {
      C_NOP, C_LOAD, C_INIT, C_DIV_STEP, C_NEED, C_RD_SCAN, C_CHK,
      C_SU_SET1, C_SU_SET2, C_SU_RD, C_SU_WR,
      C_W_ALLOC_SPLIT, C_W_ALLOC_HEAD, C_W_FH_TAIL, C_W_FH_HEAD,
      C_W_FR_HEAD, C_W_FR_MID, C_W_FR_TAIL,
      C_RD_NEXT, C_RD_PREV, C_W_MERGE_NEXT, C_W_MERGE_PREV,
      C_DR_RD, C_DR_WR, C_DR_END, C_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type       op;
      logic [ST_W-1:0] code;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic len_zero;
      logic div_last;
      logic scan_more;
      logic match;
      logic split;
      logic full1;
      logic full2;
      logic e_free;
      logic at_base;
      logic len_gt;
      logic len_lt;
      logic su_more;
      logic dr_more;
      logic has_next;
      logic has_prev;
      logic rd_free;
      logic out_free;
   } dp_status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_INIT, S_DIV, S_NEED, S_SCAN_RD, S_SCAN_CHK,
      S_A_DEC, S_A_SPLIT, S_A_HEAD,
      S_F_DEC, S_FH_TAIL, S_FH_HEAD, S_FR_HEAD, S_FR_MID, S_FR_TAIL,
      S_SU_SET1, S_SU_SET2, S_SU_CHK, S_SU_WR,
      S_MG_N, S_MG_NCHK, S_MG_P, S_MG_PCHK,
      S_DR_CHK, S_DR_WR, S_RESP
   } state_type;

endpackage

### src/first_fit_range_allocator_partial_free_unit.sv
// allocate scans the block table one entry at a time and shifts entries on a split;
//   free scans, shifts, and merges neighbours by dropping entries; one request in flight
// a new request is taken only back in idle, after the last result is posted; the
//   rounding multiply takes two steps
// reset: synchronous, clears table count, table-loaded flag and result valid
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// first_fit_range_allocator_partial_free_unit
// first-fit range allocator with partial release and coalescing of neighbours
// ---------------------------------------------------------------------------
`include "first_fit_range_allocator_partial_free_unit_macros.svh"
module first_fit_range_allocator_partial_free_unit import ffra_pkg::*; #(
   parameter int MAX_BLOCKS = 64,
   parameter int MIN_BLOCK  = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // address[35:0], length[67:36], zero pad
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status[2:0], granted_address[38:3], zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic [ADDR_W-1:0] region_base_ff;
   logic [SIZE_W-1:0] region_size_ff;
   cmd_type           cmd;
   dp_status_type     sts;
   logic [ST_W-1:0]   rsp_status;
   logic [ADDR_W-1:0] rsp_granted;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= '0;
         region_size_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[3] == REG_BASE) region_base_ff <= csr_pwdata[ADDR_W-1:0];
         else region_size_ff <= csr_pwdata[SIZE_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] == REG_SIZE) ? 64'(region_size_ff)
                                                  : 64'(region_base_ff);

   ffra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ffra_dp #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .MIN_BLOCK  (MIN_BLOCK)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_op      (req_tuser),
      .req_address (req_tdata[35:0]),
      .req_length  (req_tdata[67:36]),
      .region_base (region_base_ff),
      .region_size (region_size_ff),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_status),
      .rsp_granted (rsp_granted)
   );

   // result word
   assign rsp_tdata = {1'b0, rsp_granted, rsp_status};

   // checks
   `FFRA_ASSERT_NXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   `FFRA_ASSERT_IMP(a_finish_free, clock, reset, cmd.op == C_FINISH, !rsp_tvalid || rsp_tready)
   `FFRA_ASSERT_IMP(a_idle_quiet, clock, reset, req_tready, cmd.op == C_NOP || cmd.op == C_LOAD)

endmodule

### src/ffra_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffra_ctrl
// sequencer: scan, shift, split, release and merge steps of one request
// ---------------------------------------------------------------------------
module ffra_ctrl import ffra_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type sts,
   output cmd_type       cmd
);

   state_type       state_ff, state_in;
   state_type       ret_ff, ret_in;
   logic [ST_W-1:0] st_ff, st_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         st_ff    <= ST_OK;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         st_ff    <= st_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      st_in    = st_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_INIT;
         end
         S_INIT: begin
            if (sts.op == OP_FREE) state_in = S_SCAN_RD;
            else if (sts.len_zero) begin
               st_in = ST_BADLEN; state_in = S_RESP;
            end else state_in = S_DIV;
         end
         S_DIV: begin
            if (sts.div_last) state_in = S_NEED;
         end
         S_NEED: state_in = S_SCAN_RD;
         S_SCAN_RD: begin
            if (sts.scan_more) state_in = S_SCAN_CHK;
            else begin
               st_in    = (sts.op == OP_FREE) ? ST_NOTFOUND : ST_NOFIT;
               state_in = S_RESP;
            end
         end
         S_SCAN_CHK: begin
            if (sts.match) state_in = (sts.op == OP_FREE) ? S_F_DEC : S_A_DEC;
            else state_in = S_SCAN_RD;
         end
         S_A_DEC: begin
            if (!sts.split) state_in = S_A_HEAD;
            else if (sts.full1) begin
               st_in = ST_FULL; state_in = S_RESP;
            end else begin
               ret_in = S_A_SPLIT; state_in = S_SU_SET1;
            end
         end
         S_A_SPLIT: state_in = S_A_HEAD;
         S_A_HEAD: begin
            st_in = ST_OK; state_in = S_RESP;
         end
         S_F_DEC: begin
            if (sts.e_free) begin
               st_in = ST_NOTFOUND; state_in = S_RESP;
            end else if (sts.len_zero || sts.len_gt) begin
               st_in = ST_BADLEN; state_in = S_RESP;
            end else if (sts.at_base) begin
               if (!sts.len_lt) state_in = S_FH_HEAD;
               else if (sts.full1) begin
                  st_in = ST_FULL; state_in = S_RESP;
               end else begin
                  ret_in = S_FH_TAIL; state_in = S_SU_SET1;
               end
            end else if (sts.len_lt ? sts.full2 : sts.full1) begin
               st_in = ST_FULL; state_in = S_RESP;
            end else state_in = S_FR_HEAD;
         end
         S_FH_TAIL: state_in = S_FH_HEAD;
         S_FH_HEAD: state_in = S_MG_N;
         S_FR_HEAD: begin
            ret_in = S_FR_MID; state_in = S_SU_SET1;
         end
         S_FR_MID: begin
            if (sts.len_lt) begin
               ret_in = S_FR_TAIL; state_in = S_SU_SET2;
            end else state_in = S_MG_N;
         end
         S_FR_TAIL: state_in = S_MG_N;
         S_SU_SET1, S_SU_SET2: state_in = S_SU_CHK;
         S_SU_CHK: state_in = sts.su_more ? S_SU_WR : ret_ff;
         S_SU_WR: state_in = S_SU_CHK;
         S_MG_N: state_in = sts.has_next ? S_MG_NCHK : S_MG_P;
         S_MG_NCHK: begin
            if (sts.rd_free) begin
               ret_in = S_MG_P; state_in = S_DR_CHK;
            end else state_in = S_MG_P;
         end
         S_MG_P: begin
            st_in = ST_OK;
            state_in = sts.has_prev ? S_MG_PCHK : S_RESP;
         end
         S_MG_PCHK: begin
            st_in = ST_OK;
            if (sts.rd_free) begin
               ret_in = S_RESP; state_in = S_DR_CHK;
            end else state_in = S_RESP;
         end
         S_DR_CHK: state_in = sts.dr_more ? S_DR_WR : ret_ff;
         S_DR_WR: state_in = S_DR_CHK;
         S_RESP: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd.op     = C_NOP;
      cmd.code   = st_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = C_LOAD;
         end
         S_INIT:     cmd.op = (sts.op == OP_ALLOC) ? C_INIT : C_NOP;
         S_DIV:      cmd.op = C_DIV_STEP;
         S_NEED:     cmd.op = C_NEED;
         S_SCAN_RD:  cmd.op = sts.scan_more ? C_RD_SCAN : C_NOP;
         S_SCAN_CHK: cmd.op = C_CHK;
         S_A_SPLIT:  cmd.op = C_W_ALLOC_SPLIT;
         S_A_HEAD:   cmd.op = C_W_ALLOC_HEAD;
         S_FH_TAIL:  cmd.op = C_W_FH_TAIL;
         S_FH_HEAD:  cmd.op = C_W_FH_HEAD;
         S_FR_HEAD:  cmd.op = C_W_FR_HEAD;
         S_FR_MID:   cmd.op = C_W_FR_MID;
         S_FR_TAIL:  cmd.op = C_W_FR_TAIL;
         S_SU_SET1:  cmd.op = C_SU_SET1;
         S_SU_SET2:  cmd.op = C_SU_SET2;
         S_SU_CHK:   cmd.op = sts.su_more ? C_SU_RD : C_NOP;
         S_SU_WR:    cmd.op = C_SU_WR;
         S_MG_N:     cmd.op = sts.has_next ? C_RD_NEXT : C_NOP;
         S_MG_NCHK:  cmd.op = sts.rd_free ? C_W_MERGE_NEXT : C_NOP;
         S_MG_P:     cmd.op = sts.has_prev ? C_RD_PREV : C_NOP;
         S_MG_PCHK:  cmd.op = sts.rd_free ? C_W_MERGE_PREV : C_NOP;
         S_DR_CHK:   cmd.op = sts.dr_more ? C_DR_RD : C_DR_END;
         S_DR_WR:    cmd.op = C_DR_WR;
         S_RESP:     cmd.op = sts.out_free ? C_FINISH : C_NOP;
         default:    cmd.op = C_NOP;
      endcase
   end

endmodule

### src/ffra_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffra_dp
// block table memory, request registers, rounding multiplier and result word
// ---------------------------------------------------------------------------
module ffra_dp import ffra_pkg::*; #(
   parameter int MAX_BLOCKS = 64,
   parameter int MIN_BLOCK  = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output dp_status_type     sts,
   input  logic              req_op,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [LEN_W-1:0]  req_length,
   input  logic [ADDR_W-1:0] region_base,
   input  logic [SIZE_W-1:0] region_size,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ST_W-1:0]   rsp_status,
   output logic [ADDR_W-1:0] rsp_granted
);

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int NW = LEN_W + 1;
   // reciprocal of the minimum block, exact quotient for every 32-bit length
   localparam int SH = LEN_W + $clog2(MIN_BLOCK);
   localparam int RW = LEN_W + 1;
   localparam int PW = LEN_W + RW;
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SH) + 64'(MIN_BLOCK) - 64'd1) / 64'(MIN_BLOCK);
   localparam logic [RW-1:0] RECIP = RW'(RECIP_WIDE);

   // block table
   blk_type mem [MAX_BLOCKS];
   blk_type rd_ff;
   logic    wen;
   logic    ren;
   logic [IW-1:0] waddr, raddr;
   blk_type wdata;

   logic              op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [PW-1:0]     prod_ff;
   logic [LEN_W-1:0]  qm_ff;
   logic              div_ph_ff;
   logic [NW-1:0]     need_ff;
   logic [CW-1:0]     count_ff, idx_ff, k_ff, pos_ff;
   logic              ready_ff;
   logic [IW-1:0]     hit_ff, cur_ff;
   blk_type           e_ff;
   logic [ADDR_W-1:0] c_base_ff;
   logic [SIZE_W-1:0] c_size_ff;
   logic              rsp_valid_ff;
   logic [ST_W-1:0]   rsp_status_ff;
   logic [ADDR_W-1:0] rsp_granted_ff;

   logic [LEN_W-1:0]  quo;
   logic [ADDR_W+1:0] rd_end, e_rest;
   logic [ADDR_W+1:0] len_x;
   logic              rd_match;
   logic [CW-1:0]     k_dn;
   logic [CW:0]       k_up;
   logic [CW-1:0]     hit_p1, hit_p2;
   logic [IW-1:0]     cur_p1, cur_m1;

   // quotient of length by the minimum block from the reciprocal product
   always_comb begin
      quo = LEN_W'(prod_ff >> SH);
   end

   // address helpers
   always_comb begin
      rd_end   = (ADDR_W+2)'(rd_ff.base) + (ADDR_W+2)'(rd_ff.size);
      e_rest   = (ADDR_W+2)'(e_ff.base) + (ADDR_W+2)'(e_ff.size) - (ADDR_W+2)'(addr_ff);
      len_x    = (ADDR_W+2)'(len_ff);
      rd_match = (op_ff == OP_FREE)
                 ? ((rd_ff.base == addr_ff) ||
                    ((rd_ff.base < addr_ff) && (rd_end > (ADDR_W+2)'(addr_ff))))
                 : (rd_ff.free && (rd_ff.size >= SIZE_W'(need_ff)));
      k_dn     = k_ff - 1'b1;
      k_up     = {1'b0, k_ff} + 1'b1;
      hit_p1   = CW'(hit_ff) + 1'b1;
      hit_p2   = CW'(hit_ff) + 2'd2;
      cur_p1   = cur_ff + 1'b1;
      cur_m1   = cur_ff - 1'b1;
   end

   // status to the sequencer
   always_comb begin
      sts.op        = op_ff;
      sts.len_zero  = (len_ff == '0);
      sts.div_last  = div_ph_ff;
      sts.scan_more = (idx_ff < count_ff);
      sts.match     = rd_match;
      sts.split     = (e_ff.size != SIZE_W'(need_ff));
      sts.full1     = (count_ff == CW'(MAX_BLOCKS));
      sts.full2     = (count_ff >= CW'(MAX_BLOCKS - 1));
      sts.e_free    = e_ff.free;
      sts.at_base   = (e_ff.base == addr_ff);
      sts.len_gt    = sts.at_base ? (SIZE_W'(len_ff) > e_ff.size) : (len_x > e_rest);
      sts.len_lt    = sts.at_base ? (SIZE_W'(len_ff) < e_ff.size) : (len_x < e_rest);
      sts.su_more   = (k_ff > pos_ff);
      sts.dr_more   = (k_up < {1'b0, count_ff});
      sts.has_next  = ((CW+1)'(cur_ff) + 1'b1) < (CW+1)'(count_ff);
      sts.has_prev  = (cur_ff != '0);
      sts.rd_free   = rd_ff.free;
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // table write and read port selection
   always_comb begin
      wen   = 1'b0;
      ren   = 1'b0;
      waddr = hit_ff;
      raddr = idx_ff[IW-1:0];
      wdata = e_ff;
      case (cmd.op)
         C_INIT: begin
            wen   = !ready_ff;
            waddr = '0;
            wdata = '{base: region_base, size: region_size, free: 1'b1};
         end
         C_RD_SCAN: ren = 1'b1;
         C_SU_RD: begin
            ren = 1'b1; raddr = k_dn[IW-1:0];
         end
         C_SU_WR: begin
            wen = 1'b1; waddr = k_ff[IW-1:0]; wdata = rd_ff;
         end
         C_DR_RD: begin
            ren = 1'b1; raddr = k_up[IW-1:0];
         end
         C_DR_WR: begin
            wen = 1'b1; waddr = k_ff[IW-1:0]; wdata = rd_ff;
         end
         C_W_ALLOC_SPLIT: begin
            wen   = 1'b1; waddr = hit_p1[IW-1:0];
            wdata = '{base: e_ff.base + ADDR_W'(need_ff),
                      size: e_ff.size - SIZE_W'(need_ff), free: 1'b1};
         end
         C_W_ALLOC_HEAD: begin
            wen   = 1'b1;
            wdata = '{base: e_ff.base, size: SIZE_W'(need_ff), free: 1'b0};
         end
         C_W_FH_TAIL: begin
            wen   = 1'b1; waddr = hit_p1[IW-1:0];
            wdata = '{base: addr_ff + ADDR_W'(len_ff),
                      size: e_ff.size - SIZE_W'(len_ff), free: 1'b0};
         end
         C_W_FH_HEAD: begin
            wen   = 1'b1;
            wdata = '{base: e_ff.base, size: SIZE_W'(len_ff), free: 1'b1};
         end
         C_W_FR_HEAD: begin
            wen   = 1'b1;
            wdata = '{base: e_ff.base, size: SIZE_W'(addr_ff - e_ff.base), free: 1'b0};
         end
         C_W_FR_MID: begin
            wen   = 1'b1; waddr = hit_p1[IW-1:0];
            wdata = '{base: addr_ff, size: SIZE_W'(len_ff), free: 1'b1};
         end
         C_W_FR_TAIL: begin
            wen   = 1'b1; waddr = hit_p2[IW-1:0];
            wdata = '{base: addr_ff + ADDR_W'(len_ff),
                      size: SIZE_W'(e_rest - len_x), free: 1'b0};
         end
         C_RD_NEXT: begin
            ren = 1'b1; raddr = cur_p1;
         end
         C_RD_PREV: begin
            ren = 1'b1; raddr = cur_m1;
         end
         C_W_MERGE_NEXT: begin
            wen   = 1'b1; waddr = cur_ff;
            wdata = '{base: c_base_ff, size: c_size_ff + rd_ff.size, free: 1'b1};
         end
         C_W_MERGE_PREV: begin
            wen   = 1'b1; waddr = cur_m1;
            wdata = '{base: rd_ff.base, size: rd_ff.size + c_size_ff, free: 1'b1};
         end
         default: wen = 1'b0;
      endcase
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (wen) mem[waddr] <= wdata;
      if (ren) rd_ff <= mem[raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (cmd.op)
            C_INIT: begin
               if (!ready_ff) begin
                  count_ff <= CW'(1);
                  ready_ff <= 1'b1;
               end
            end
            C_W_ALLOC_SPLIT, C_W_FH_TAIL, C_W_FR_MID, C_W_FR_TAIL:
               count_ff <= count_ff + 1'b1;
            C_DR_END: count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
         if (cmd.op == C_FINISH) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         C_LOAD: begin
            op_ff     <= req_op;
            addr_ff   <= req_address;
            len_ff    <= req_length;
            div_ph_ff <= 1'b0;
            idx_ff    <= '0;
         end
         // first step forms the product, second the rounded-down multiple
         C_DIV_STEP: begin
            prod_ff   <= PW'(len_ff) * PW'(RECIP);
            qm_ff     <= quo * LEN_W'(MIN_BLOCK);
            div_ph_ff <= 1'b1;
         end
         C_NEED: need_ff <= (qm_ff == len_ff) ? NW'(qm_ff)
                                              : NW'(qm_ff) + NW'(MIN_BLOCK);
         C_CHK: begin
            if (rd_match) begin
               e_ff   <= rd_ff;
               hit_ff <= idx_ff[IW-1:0];
            end else idx_ff <= idx_ff + 1'b1;
         end
         C_SU_SET1: begin
            k_ff <= count_ff; pos_ff <= hit_p1;
         end
         C_SU_SET2: begin
            k_ff <= count_ff; pos_ff <= hit_p2;
         end
         C_SU_WR: k_ff <= k_dn;
         C_DR_WR: k_ff <= k_up[CW-1:0];
         C_W_FH_HEAD: begin
            cur_ff <= hit_ff; c_base_ff <= e_ff.base; c_size_ff <= SIZE_W'(len_ff);
         end
         C_W_FR_MID: begin
            cur_ff <= hit_p1[IW-1:0]; c_base_ff <= addr_ff; c_size_ff <= SIZE_W'(len_ff);
         end
         C_W_MERGE_NEXT: begin
            c_size_ff <= c_size_ff + rd_ff.size;
            k_ff      <= CW'(cur_p1);
         end
         C_W_MERGE_PREV: k_ff <= CW'(cur_ff);
         C_FINISH: begin
            rsp_status_ff  <= cmd.code;
            rsp_granted_ff <= ((cmd.code == ST_OK) && (op_ff == OP_ALLOC)) ? e_ff.base : '0;
         end
         default: k_ff <= k_ff;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_granted = rsp_granted_ff;

endmodule
